/* rtl/core/xfbr_pkg.sv */
// Package for the XOR-framed bus receiver: protocol byte codes, event codes,
// register indexes and default sizes. No dependencies.
`timescale 1ns / 1ps

package xfbr_pkg;

  // Default frame size limit in bytes, start byte included.
  localparam int MAX_FRAME_DEF = 128;

  // Protocol bytes.
  localparam logic [7:0] START_BYTE   = 8'h5C;
  localparam logic [7:0] ALT_SUM      = 8'hC5;
  localparam logic [7:0] READ_CMD     = 8'h69;
  localparam logic [7:0] WRITE_CMD    = 8'h6B;
  localparam logic [7:0] TOKEN_ADDR   = 8'h20;
  localparam logic [7:0] TOKEN_SECOND = 8'h00;
  localparam logic [7:0] TOKEN_LEN    = 8'h00;

  // Frame layout: positions of the header fields and the header size.
  localparam int POS_SECOND = 1;
  localparam int POS_ADDR   = 2;
  localparam int POS_CMD    = 3;
  localparam int POS_LEN    = 4;
  localparam int HDR_BYTES  = 5;

  // Event codes reported with each result transaction.
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_DROP  = 3'd1,
    EV_CRC   = 3'd2,
    EV_MSG   = 3'd3,
    EV_READ  = 3'd4,
    EV_WRITE = 3'd5
  } ev_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ACK_EN    = 3'd0,
    REG_ACK_U1    = 3'd1,
    REG_ACK_U2    = 3'd2,
    REG_ACK_U3    = 3'd3,
    REG_U1_ADDR   = 3'd4,
    REG_U2_ADDR   = 3'd5,
    REG_U3_ADDR   = 3'd6
  } reg_idx_t;

  // Register reset values.
  localparam logic       ACK_EN_RST  = 1'b1;
  localparam logic       ACK_U1_RST  = 1'b1;
  localparam logic       ACK_U2_RST  = 1'b0;
  localparam logic       ACK_U3_RST  = 1'b0;
  localparam logic [7:0] U1_ADDR_RST = 8'd32;
  localparam logic [7:0] U2_ADDR_RST = 8'd25;
  localparam logic [7:0] U3_ADDR_RST = 8'd22;

endpackage

/* rtl/core/xor_framed_bus_receiver.sv */
// A result is loaded into the output register by the edge that accepts its input transaction.
// One byte per cycle while in_stall is low; the frame state advances with each byte.
// The input stalls only while a finished result waits in the output register and the
// output is stalled. Reset (rst_n low, synchronous) returns to hunting for the start byte,
// empties the output register and loads the register defaults.
// Depends on xfbr_pkg.
`timescale 1ns / 1ps

module xor_framed_bus_receiver #(
  parameter int MAX_FRAME = xfbr_pkg::MAX_FRAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration write port
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  // Input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_data_byte,
  output logic       out_in_frame,
  output logic [6:0] out_byte_position,
  output logic [2:0] out_event_res,
  output logic       out_send_ack,
  output logic       out_send_nak,
  output logic       out_ack_allowed,
  output logic [7:0] out_frame_length,
  output logic [7:0] out_frame_address
);

  // Byte counter holds up to MAX_FRAME; compares run wide enough for length + header.
  localparam int CW   = $clog2(MAX_FRAME + 1);
  localparam int CMPW = (CW > 9) ? CW : 9;

  // Configuration registers.
  logic       ack_en_r, ack_u1_r, ack_u2_r, ack_u3_r;
  logic [7:0] u1_addr_r, u2_addr_r, u3_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_en_r  <= xfbr_pkg::ACK_EN_RST;
      ack_u1_r  <= xfbr_pkg::ACK_U1_RST;
      ack_u2_r  <= xfbr_pkg::ACK_U2_RST;
      ack_u3_r  <= xfbr_pkg::ACK_U3_RST;
      u1_addr_r <= xfbr_pkg::U1_ADDR_RST;
      u2_addr_r <= xfbr_pkg::U2_ADDR_RST;
      u3_addr_r <= xfbr_pkg::U3_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        xfbr_pkg::REG_ACK_EN:  ack_en_r  <= cfg_data[0];
        xfbr_pkg::REG_ACK_U1:  ack_u1_r  <= cfg_data[0];
        xfbr_pkg::REG_ACK_U2:  ack_u2_r  <= cfg_data[0];
        xfbr_pkg::REG_ACK_U3:  ack_u3_r  <= cfg_data[0];
        xfbr_pkg::REG_U1_ADDR: u1_addr_r <= cfg_data;
        xfbr_pkg::REG_U2_ADDR: u2_addr_r <= cfg_data;
        xfbr_pkg::REG_U3_ADDR: u3_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: the output register is free when empty or being drained.
  logic out_valid_r;
  logic in_accept;

  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  // Frame state.
  logic          phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic [7:0]    second_r, second_nxt;
  logic [7:0]    addr_r, addr_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [7:0]    plen_r, plen_nxt;

  // Result fields computed for the byte being accepted.
  logic          res_stored;
  logic [6:0]    res_pos;
  xfbr_pkg::ev_t res_ev;
  logic          res_ack, res_nak, res_allowed;
  logic [7:0]    res_len, res_addr;

  logic [CMPW-1:0] count_ext;
  logic [CMPW-1:0] end_pos;
  logic            at_end;
  logic            qualifies;
  logic            sum_ok;
  logic            is_token;

  // Address match against the units that are enabled for replies.
  assign qualifies = ack_en_r && ((addr_r == u1_addr_r && ack_u1_r) ||
                                  (addr_r == u2_addr_r && ack_u2_r) ||
                                  (addr_r == u3_addr_r && ack_u3_r));

  assign count_ext = CMPW'(count_r);
  assign end_pos   = CMPW'(plen_r) + CMPW'(xfbr_pkg::HDR_BYTES);
  assign at_end    = (count_ext >= CMPW'(xfbr_pkg::HDR_BYTES)) && (count_ext == end_pos);
  assign sum_ok    = (xor_r == in_rx_byte) ||
                     (xor_r == xfbr_pkg::START_BYTE && in_rx_byte == xfbr_pkg::ALT_SUM);
  assign is_token  = (second_r == xfbr_pkg::TOKEN_SECOND) &&
                     (addr_r == xfbr_pkg::TOKEN_ADDR) &&
                     (plen_r == xfbr_pkg::TOKEN_LEN) &&
                     (cmd_r == xfbr_pkg::READ_CMD || cmd_r == xfbr_pkg::WRITE_CMD);

  // Next frame state and the result for one byte.
  always_comb begin
    phase_nxt   = phase_r;
    count_nxt   = count_r;
    xor_nxt     = xor_r;
    second_nxt  = second_r;
    addr_nxt    = addr_r;
    cmd_nxt     = cmd_r;
    plen_nxt    = plen_r;
    res_stored  = 1'b0;
    res_pos     = '0;
    res_ev      = xfbr_pkg::EV_NONE;
    res_ack     = 1'b0;
    res_nak     = 1'b0;
    res_allowed = 1'b0;
    res_len     = '0;
    res_addr    = '0;

    if (!phase_r) begin
      // Hunting: only the start byte opens a frame.
      if (in_rx_byte == xfbr_pkg::START_BYTE) begin
        phase_nxt  = 1'b1;
        count_nxt  = CW'(1);
        xor_nxt    = '0;
        res_stored = 1'b1;
      end
    end else if (count_ext >= CMPW'(MAX_FRAME)) begin
      // Frame grew past the limit: drop it without looking at this byte.
      phase_nxt = 1'b0;
      res_ev    = xfbr_pkg::EV_DROP;
    end else begin
      count_nxt  = count_r + CW'(1);
      res_stored = 1'b1;
      res_pos    = count_ext[6:0];
      if (at_end) begin
        // Check byte: close the frame and classify it.
        phase_nxt   = 1'b0;
        res_addr    = addr_r;
        res_allowed = qualifies;
        if (!sum_ok) begin
          res_ev  = xfbr_pkg::EV_CRC;
          res_nak = qualifies;
        end else begin
          res_len = count_ext[7:0] + 8'd1;
          if (is_token) begin
            res_ev = (cmd_r == xfbr_pkg::WRITE_CMD) ? xfbr_pkg::EV_WRITE : xfbr_pkg::EV_READ;
          end else begin
            res_ev  = xfbr_pkg::EV_MSG;
            res_ack = qualifies;
          end
        end
      end else begin
        // Body byte: fold into the check and capture header fields.
        xor_nxt = xor_r ^ in_rx_byte;
        if (count_ext == CMPW'(xfbr_pkg::POS_SECOND)) second_nxt = in_rx_byte;
        if (count_ext == CMPW'(xfbr_pkg::POS_ADDR))   addr_nxt   = in_rx_byte;
        if (count_ext == CMPW'(xfbr_pkg::POS_CMD))    cmd_nxt    = in_rx_byte;
        if (count_ext == CMPW'(xfbr_pkg::POS_LEN))    plen_nxt   = in_rx_byte;
      end
    end
  end

  // Frame state registers advance on each accepted transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= 1'b0;
      count_r  <= '0;
      xor_r    <= '0;
      second_r <= '0;
      addr_r   <= '0;
      cmd_r    <= '0;
      plen_r   <= '0;
    end else if (in_accept) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      xor_r    <= xor_nxt;
      second_r <= second_nxt;
      addr_r   <= addr_nxt;
      cmd_r    <= cmd_nxt;
      plen_r   <= plen_nxt;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload register, loaded with each accepted transaction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_byte     <= in_rx_byte;
      out_in_frame      <= res_stored;
      out_byte_position <= res_pos;
      out_event_res     <= res_ev;
      out_send_ack      <= res_ack;
      out_send_nak      <= res_nak;
      out_ack_allowed   <= res_allowed;
      out_frame_length  <= res_len;
      out_frame_address <= res_addr;
    end
  end

endmodule

/* rtl/core/xfbr_checker.sv */
// Port-level checks for the XOR-framed bus receiver, bound to the top level.
// Depends on xfbr_pkg and the port list of xor_framed_bus_receiver.
`timescale 1ns / 1ps

module xfbr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_data_byte,
  input logic       out_in_frame,
  input logic [6:0] out_byte_position,
  input logic [2:0] out_event_res,
  input logic       out_send_ack,
  input logic       out_send_nak
);

  // A stalled result holds its echoed byte and event.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) && $stable(out_event_res))
    else $error("stalled result changed");

  // The input is held back only while a result waits in the output register.
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output register");

  // An accepted byte always yields a result on the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  // ACK only on ordinary messages, NAK only on checksum failures.
  a_reply_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_send_ack || out_event_res == xfbr_pkg::EV_MSG) &&
                  (!out_send_nak || out_event_res == xfbr_pkg::EV_CRC))
    else $error("reply flag on wrong event");

  // A byte outside a frame carries no position.
  a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_frame |-> out_byte_position == 7'd0)
    else $error("position reported for unstored byte");

endmodule

bind xor_framed_bus_receiver xfbr_checker u_xfbr_checker (.*);

/* tb/sv/xor_framed_bus_receiver_tb.sv */
// Self-checking testbench for xor_framed_bus_receiver: directed frames, then random
// frame traffic under several register settings and idle patterns.
// Depends on xfbr_pkg and the xor_framed_bus_receiver RTL.
`timescale 1ns / 1ps

module xor_framed_bus_receiver_tb;
  import xfbr_pkg::*;

  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [2:0] REG_NONE = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       in_frame;
    logic [6:0] pos;
    ev_t        ev;
    logic       ack;
    logic       nak;
    logic       allowed;
    logic [7:0] len;
    logic [7:0] addr;
  } rx_result_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    rx_result_t res;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_data_byte;
  logic       out_in_frame;
  logic [6:0] out_byte_position;
  logic [2:0] out_event_res;
  logic       out_send_ack;
  logic       out_send_nak;
  logic       out_ack_allowed;
  logic [7:0] out_frame_length;
  logic [7:0] out_frame_address;

  // Frame decoder state, mirrored from the block.
  logic       framing = 1'b0;
  int         frame_cnt = 0;
  logic [7:0] frame_xor = 8'd0;
  logic [7:0] hdr_second = 8'd0;
  logic [7:0] hdr_addr = 8'd0;
  logic [7:0] hdr_cmd = 8'd0;
  logic [7:0] hdr_len = 8'd0;

  // Register copy.
  logic       ack_on = ACK_EN_RST;
  logic       unit_ack [3] = '{ACK_U1_RST, ACK_U2_RST, ACK_U3_RST};
  logic [7:0] unit_addr [3] = '{U1_ADDR_RST, U2_ADDR_RST, U3_ADDR_RST};

  rx_result_t pending_results [$];
  dir_row_t   dir_rows [$];
  bit         row_typed = 1'b0;
  rx_result_t row_result = '0;
  int         mism_count = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         frame_bytes_sent = 0;

  xor_framed_bus_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_byte     (out_data_byte),
    .out_in_frame      (out_in_frame),
    .out_byte_position (out_byte_position),
    .out_event_res     (out_event_res),
    .out_send_ack      (out_send_ack),
    .out_send_nak      (out_send_nak),
    .out_ack_allowed   (out_ack_allowed),
    .out_frame_length  (out_frame_length),
    .out_frame_address (out_frame_address)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // An address qualifies for a reply when replies are enabled and a unit
  // with its reply bit set owns that address.
  function automatic logic addr_qualifies(input logic [7:0] a);
    if (!ack_on) return 1'b0;
    for (int u = 0; u < 3; u++) begin
      if (unit_ack[u] && a == unit_addr[u]) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the decoder by one received byte and returns the result it causes.
  function automatic rx_result_t decode_rx_byte(input logic [7:0] b);
    rx_result_t r;
    logic       q;
    logic       ok;
    int         p;
    r = '0;
    r.data_byte = b;
    r.ev = EV_NONE;
    if (!framing) begin
      if (b == START_BYTE) begin
        framing = 1'b1;
        frame_cnt = 1;
        frame_xor = 8'd0;
        r.in_frame = 1'b1;
      end
    end else if (frame_cnt >= MAX_FRAME_DEF) begin
      // Frame grew too long: this byte is dropped and hunting resumes.
      framing = 1'b0;
      r.ev = EV_DROP;
    end else begin
      p = frame_cnt;
      frame_cnt = p + 1;
      r.in_frame = 1'b1;
      r.pos = p[6:0];
      if (p >= HDR_BYTES && p == int'(hdr_len) + HDR_BYTES) begin
        q = addr_qualifies(hdr_addr);
        ok = (frame_xor == b) || (frame_xor == START_BYTE && b == ALT_SUM);
        framing = 1'b0;
        r.addr = hdr_addr;
        r.allowed = q;
        if (!ok) begin
          r.ev = EV_CRC;
          r.nak = q;
        end else begin
          r.len = 8'(p + 1);
          if (hdr_second == TOKEN_SECOND && hdr_addr == TOKEN_ADDR && hdr_len == TOKEN_LEN &&
              (hdr_cmd == READ_CMD || hdr_cmd == WRITE_CMD)) begin
            r.ev = (hdr_cmd == WRITE_CMD) ? EV_WRITE : EV_READ;
          end else begin
            r.ev = EV_MSG;
            r.ack = q;
          end
        end
      end else begin
        frame_xor ^= b;
        case (p)
          POS_SECOND: hdr_second = b;
          POS_ADDR:   hdr_addr = b;
          POS_CMD:    hdr_cmd = b;
          POS_LEN:    hdr_len = b;
          default: ;
        endcase
      end
    end
    return r;
  endfunction

  function automatic rx_result_t mk(input logic [7:0] b, input logic inf, input logic [6:0] pos,
                                    input ev_t ev, input logic ack, input logic nak,
                                    input logic alw, input logic [7:0] len,
                                    input logic [7:0] adr);
    return '{b, inf, pos, ev, ack, nak, alw, len, adr};
  endfunction

  // Receiver side: random stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Accepted input transactions feed the decoder; accepted result transactions
  // are checked against the oldest expectation.
  always @(posedge clk) begin : monitor
    rx_result_t want;
    rx_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = decode_rx_byte(in_rx_byte);
        if (row_typed) want = row_result;
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{out_data_byte, out_in_frame, out_byte_position, ev_t'(out_event_res),
                out_send_ack, out_send_nak, out_ack_allowed, out_frame_length,
                out_frame_address};
        if (pending_results.size() == 0) begin
          mism_count++;
          if (mism_count <= 10)
            $display("%0t: unexpected result transaction: byte=%h inf=%b pos=%0d ev=%0d",
                     $realtime, got.data_byte, got.in_frame, got.pos, got.ev);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mism_count++;
            if (mism_count <= 10) begin
              $display("%0t: result differs", $realtime);
              $display("  expected byte=%h inf=%b pos=%0d ev=%0d ack=%b nak=%b alw=%b len=%0d adr=%h",
                       want.data_byte, want.in_frame, want.pos, want.ev, want.ack,
                       want.nak, want.allowed, want.len, want.addr);
              $display("  actual   byte=%h inf=%b pos=%0d ev=%0d ack=%b nak=%b alw=%b len=%0d adr=%h",
                       got.data_byte, got.in_frame, got.pos, got.ev, got.ack,
                       got.nak, got.allowed, got.len, got.addr);
            end
          end
        end
      end
    end
  end

  // Sends one byte, with random idle cycles in front, and returns at the
  // falling edge after the transaction was accepted.
  task automatic send_byte(input logic [7:0] b, input bit typed, input rx_result_t res);
    row_typed = typed;
    row_result = res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops sending and waits until every expected result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ACK_EN:  ack_on = val[0];
      REG_ACK_U1:  unit_ack[0] = val[0];
      REG_ACK_U2:  unit_ack[1] = val[0];
      REG_ACK_U3:  unit_ack[2] = val[0];
      REG_U1_ADDR: unit_addr[0] = val;
      REG_U2_ADDR: unit_addr[1] = val;
      REG_U3_ADDR: unit_addr[2] = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Writes the full register set, plus a write to the unused index.
  task automatic program_units(input logic en, input logic a1, input logic a2, input logic a3,
                               input logic [7:0] d1, input logic [7:0] d2,
                               input logic [7:0] d3);
    write_reg(REG_ACK_EN, {7'd0, en});
    write_reg(REG_ACK_U1, {7'($urandom_range(127)), a1});
    write_reg(REG_ACK_U2, {7'($urandom_range(127)), a2});
    write_reg(REG_ACK_U3, {7'($urandom_range(127)), a3});
    write_reg(REG_U1_ADDR, d1);
    write_reg(REG_U2_ADDR, d2);
    write_reg(REG_U3_ADDR, d3);
    write_reg(REG_NONE, 8'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Builds one random frame (token, message, overlong, good or bad check byte,
  // sometimes cut short) and sends it, with occasional line noise in front.
  task automatic send_frame();
    logic [7:0] fb [$];
    logic [7:0] adr;
    logic [7:0] plen;
    logic [7:0] x;
    int         kind;
    int         chk_kind;
    bit         overlong;
    kind = $urandom_range(99);
    overlong = 1'b0;
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, '0);
    end
    case ($urandom_range(5))
      0: adr = unit_addr[0];
      1: adr = unit_addr[1];
      2: adr = unit_addr[2];
      3: adr = TOKEN_ADDR;
      default: adr = 8'($urandom);
    endcase
    if (kind < 20) begin
      // Read or write token, now and then with one header field disturbed.
      fb = '{START_BYTE, TOKEN_SECOND, TOKEN_ADDR, $urandom_range(1) ? READ_CMD : WRITE_CMD,
             TOKEN_LEN};
      if ($urandom_range(4) == 0) fb[$urandom_range(1, 4)] = 8'($urandom_range(0, 2));
    end else begin
      if (kind < 96) plen = 8'($urandom_range(0, 8));
      else if (kind < 98) plen = 8'($urandom_range(100, 122));
      else plen = 8'($urandom_range(123, 255));
      overlong = (plen > 8'd122);
      fb = '{START_BYTE, $urandom_range(1) ? TOKEN_SECOND : 8'($urandom), adr,
             8'($urandom), plen};
      if (overlong) begin
        while (fb.size() < MAX_FRAME_DEF + 1) fb.push_back(8'($urandom));
      end else begin
        repeat (plen) fb.push_back(8'($urandom));
      end
    end
    if (!overlong) begin
      x = 8'd0;
      for (int i = 1; i < fb.size(); i++) x ^= fb[i];
      chk_kind = $urandom_range(9);
      if (chk_kind < 6) begin
        fb.push_back(x);
      end else if (chk_kind < 8) begin
        fb.push_back(x ^ 8'($urandom_range(1, 255)));
      end else begin
        // Steer the running XOR to the start byte and send the accepted alternate.
        fb[POS_CMD] ^= x ^ START_BYTE;
        fb.push_back(ALT_SUM);
      end
    end
    if ($urandom_range(11) == 0) fb = fb[0:$urandom_range(0, fb.size() - 2)];
    foreach (fb[i]) send_byte(fb[i], 1'b0, '0);
    frame_bytes_sent += fb.size();
  endtask

  // Directed rows, then phases of random frames under changing settings.
  initial begin
    dir_rows.push_back('{8'h00, 1'b1, mk(8'h00, 1'b0, 7'd0, EV_NONE, 1'b0, 1'b0, 1'b0,
                                         8'd0, 8'd0)});
    dir_rows.push_back('{8'hFF, 1'b1, mk(8'hFF, 1'b0, 7'd0, EV_NONE, 1'b0, 1'b0, 1'b0,
                                         8'd0, 8'd0)});
    // Read token to the first unit.
    dir_rows.push_back('{START_BYTE, 1'b1, mk(START_BYTE, 1'b1, 7'd0, EV_NONE, 1'b0, 1'b0,
                                              1'b0, 8'd0, 8'd0)});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h20, 1'b0, '0});
    dir_rows.push_back('{READ_CMD, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h49, 1'b1, mk(8'h49, 1'b1, 7'd5, EV_READ, 1'b0, 1'b0, 1'b1,
                                         8'd6, 8'h20)});
    // Write token.
    dir_rows.push_back('{START_BYTE, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h20, 1'b0, '0});
    dir_rows.push_back('{WRITE_CMD, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h4B, 1'b1, mk(8'h4B, 1'b1, 7'd5, EV_WRITE, 1'b0, 1'b0, 1'b1,
                                         8'd6, 8'h20)});
    // Message whose XOR is the start byte, closed by the alternate check byte.
    dir_rows.push_back('{START_BYTE, 1'b0, '0});
    dir_rows.push_back('{8'h01, 1'b0, '0});
    dir_rows.push_back('{8'h20, 1'b0, '0});
    dir_rows.push_back('{8'h7D, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{ALT_SUM, 1'b1, mk(ALT_SUM, 1'b1, 7'd5, EV_MSG, 1'b1, 1'b0, 1'b1,
                                           8'd6, 8'h20)});
    // Start bytes inside a frame are data; the check byte is wrong.
    dir_rows.push_back('{START_BYTE, 1'b0, '0});
    dir_rows.push_back('{START_BYTE, 1'b0, '0});
    dir_rows.push_back('{8'h20, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b0, '0});
    dir_rows.push_back('{8'h01, 1'b0, '0});
    dir_rows.push_back('{START_BYTE, 1'b0, '0});
    dir_rows.push_back('{8'h00, 1'b1, mk(8'h00, 1'b1, 7'd6, EV_CRC, 1'b0, 1'b1, 1'b1,
                                         8'd0, 8'h20)});

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      case (ph)
        0: ;  // reset defaults
        1: program_units(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
        2: program_units(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        3: program_units(1'b1, 1'b1, 1'b1, 1'b1, TOKEN_ADDR, 8'($urandom), 8'($urandom));
        default: program_units(1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), 1'($urandom_range(1)),
                               $urandom_range(1) ? TOKEN_ADDR : 8'($urandom),
                               8'($urandom), 8'($urandom));
      endcase
      // The last frame of a phase may overshoot the threshold.
      frame_bytes_sent = 0;
      while (frame_bytes_sent < 52) send_frame();
      drain_results();
    end

    repeat (4) @(negedge clk);
    if (mism_count == 0 && pending_results.size() == 0) begin
      $display("xor_framed_bus_receiver: match");
    end else begin
      $display("xor_framed_bus_receiver: mismatch");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("xor_framed_bus_receiver: mismatch");
    $finish;
  end

endmodule

/* files.f */
rtl/core/xfbr_pkg.sv
rtl/core/xor_framed_bus_receiver.sv
rtl/core/xfbr_checker.sv
tb/sv/xor_framed_bus_receiver_tb.sv
